/* rtl/dad_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dad_pkg
// Types and constants for the detection anchor decode unit.
// ----------------------------------------------------------------------------
package dad_pkg;

  localparam int VALUE_W         = 24;
  localparam int COORD_W         = 16;
  localparam int CLASS_W         = 6;
  localparam int POINT_IDX_W     = 2;
  localparam int CC_W            = 7;
  localparam int THR_W           = 9;
  localparam int SCALE_W         = 20;
  localparam int CFG_DATA_W      = 20;
  localparam int CFG_IDX_W       = 2;

  localparam int BOX_FIELDS      = 4;
  localparam int KEYPOINT_VALUES = 8;
  localparam int LANES           = 4;

  // 2x - w needs two extra bits over a value
  localparam int OPND_W          = VALUE_W + 2;
  localparam int PROD_W          = OPND_W + SCALE_W + 1;

  localparam logic [4:0] EDGE_SHIFT  = 5'd25;
  localparam logic [4:0] SIZE_SHIFT  = 5'd24;
  localparam logic [4:0] POINT_SHIFT = 5'd16;

  localparam logic signed [PROD_W-1:0] COORD_HI = (2 ** (COORD_W - 1)) - 1;
  localparam logic signed [PROD_W-1:0] COORD_LO = -(2 ** (COORD_W - 1));
  localparam logic signed [PROD_W-1:0] POINT_HI = (2 ** (VALUE_W - 1)) - 1;
  localparam logic signed [PROD_W-1:0] POINT_LO = -(2 ** (VALUE_W - 1));

  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE   = 2'd2;

  localparam logic [CC_W-1:0]    CLASS_COUNT_RST = 7'd1;
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = 9'd128;
  localparam logic [SCALE_W-1:0] INV_SCALE_RST   = 20'd65536;

  typedef enum logic {
    KIND_BOX   = 1'b0,
    KIND_POINT = 1'b1
  } kind_t;

  // per-result info that rides along with the operands
  typedef struct packed {
    kind_t                     kind;
    logic [CLASS_W-1:0]        class_id;
    logic signed [VALUE_W-1:0] score;
    logic [POINT_IDX_W-1:0]    point_index;
    logic                      last;
  } res_tag_t;

endpackage
`default_nettype wire

/* rtl/detection_anchor_decode_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// detection_anchor_decode_unit
// Streams one anchor's feature values, tracks the best class score and emits
// a scaled box result and four scaled keypoint results for passing anchors.
// ----------------------------------------------------------------------------
// an item with a result passes the decode, multiply and truncate-and-saturate stages to reach out_valid
// throughput: one input item per cycle; the input stalls only while a result
//   waits in the output register and out_ready is low
// the three stages (decode, multiply, truncate and saturate) advance together
// reset: pipeline emptied, anchor position, best score and pass flag cleared, registers to reset values
module detection_anchor_decode_unit #(
  parameter int MAX_CLASSES = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [dad_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [dad_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [dad_pkg::VALUE_W-1:0]     value,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        kind,
  output logic [dad_pkg::CLASS_W-1:0]                 class_id,
  output logic signed [dad_pkg::VALUE_W-1:0]          score,
  output logic signed [dad_pkg::COORD_W-1:0]          left,
  output logic signed [dad_pkg::COORD_W-1:0]          top,
  output logic signed [dad_pkg::COORD_W-1:0]          box_width,
  output logic signed [dad_pkg::COORD_W-1:0]          box_height,
  output logic [dad_pkg::POINT_IDX_W-1:0]             point_index,
  output logic signed [dad_pkg::VALUE_W-1:0]          point_x,
  output logic signed [dad_pkg::VALUE_W-1:0]          point_y,
  output logic                                        last
);
  import dad_pkg::*;

  localparam int POS_W = $clog2(BOX_FIELDS + MAX_CLASSES + KEYPOINT_VALUES + 1);
  localparam int NC_W  = $clog2(MAX_CLASSES + 1);

  // configuration
  logic [CC_W-1:0]    class_count;
  logic [THR_W-1:0]   score_threshold;
  logic [SCALE_W-1:0] inv_scale;

  // anchor state
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] best_score;
  logic [CLASS_W-1:0]        best_class;
  logic signed [VALUE_W-1:0] box_values [BOX_FIELDS];
  logic signed [VALUE_W-1:0] keypoint_x_hold;
  logic                      anchor_passed;

  // pipeline
  logic                      en;
  logic                      accept;
  logic                      s1_valid;
  res_tag_t                  s1_tag;
  logic signed [OPND_W-1:0]  s1_opnd [LANES];
  logic                      s2_valid;
  res_tag_t                  s2_tag;
  logic signed [PROD_W-1:0]  s2_prod [LANES];

  // decode
  logic [NC_W-1:0]           nc;
  logic [POS_W-1:0]          total;
  logic [POS_W-1:0]          pos_eff;
  logic [POS_W-1:0]          pos_next;
  logic [POS_W-1:0]          c;
  logic [2:0]                k;
  logic                      in_box;
  logic                      in_score;
  logic                      score_last;
  logic                      passed_eff;
  logic                      best_take;
  logic signed [VALUE_W-1:0] best_score_next;
  logic [CLASS_W-1:0]        best_class_next;
  logic                      passed_next;
  logic                      emit;
  res_tag_t                  tag_next;
  logic signed [OPND_W-1:0]  opnd_next [LANES];
  logic signed [SCALE_W:0]   scale_s;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (class_count == '0) begin
      nc = NC_W'(1);
    end else if (class_count > CC_W'(MAX_CLASSES)) begin
      nc = NC_W'(MAX_CLASSES);
    end else begin
      nc = class_count[NC_W-1:0];
    end
    total    = POS_W'(BOX_FIELDS) + POS_W'(nc) + POS_W'(KEYPOINT_VALUES);
    pos_eff  = (position >= total) ? '0 : position;
    pos_next = (pos_eff + POS_W'(1) >= total) ? '0 : pos_eff + POS_W'(1);
    c        = pos_eff - POS_W'(BOX_FIELDS);
    k        = 3'(pos_eff - POS_W'(BOX_FIELDS) - POS_W'(nc));
    in_box   = pos_eff < POS_W'(BOX_FIELDS);
    in_score = !in_box && (pos_eff < POS_W'(BOX_FIELDS) + POS_W'(nc));
    score_last = c == POS_W'(nc) - POS_W'(1);
    passed_eff = (pos_eff == '0) ? 1'b0 : anchor_passed;

    best_take = (c == '0) || (value > best_score);
    best_score_next = best_score;
    best_class_next = best_class;
    if (in_score && best_take) begin
      best_score_next = value;
      best_class_next = CLASS_W'(c);
    end
    passed_next = $signed(best_score_next) >= $signed({15'd0, score_threshold});

    emit = 1'b0;
    tag_next.kind        = KIND_BOX;
    tag_next.class_id    = best_class_next;
    tag_next.score       = best_score_next;
    tag_next.point_index = '0;
    tag_next.last        = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      opnd_next[i] = '0;
    end
    if (in_score) begin
      if (score_last && passed_next) begin
        emit = 1'b1;
      end
      opnd_next[0] = (OPND_W'(box_values[0]) <<< 1) - OPND_W'(box_values[2]);
      opnd_next[1] = (OPND_W'(box_values[1]) <<< 1) - OPND_W'(box_values[3]);
      opnd_next[2] = OPND_W'(box_values[2]);
      opnd_next[3] = OPND_W'(box_values[3]);
    end else if (!in_box) begin
      if (k[0] && passed_eff) begin
        emit = 1'b1;
      end
      tag_next.kind        = KIND_POINT;
      tag_next.point_index = k[2:1];
      tag_next.last        = k == 3'(KEYPOINT_VALUES - 1);
      opnd_next[0]         = OPND_W'(keypoint_x_hold);
      opnd_next[1]         = OPND_W'(value);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count     <= CLASS_COUNT_RST;
      score_threshold <= THRESHOLD_RST;
      inv_scale       <= INV_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLASS_COUNT: class_count     <= cfg_data[CC_W-1:0];
        REG_THRESHOLD:   score_threshold <= cfg_data[THR_W-1:0];
        REG_INV_SCALE:   inv_scale       <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // anchor state
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      best_score    <= '0;
      best_class    <= '0;
      anchor_passed <= 1'b0;
    end else if (accept) begin
      position   <= pos_next;
      best_score <= best_score_next;
      best_class <= best_class_next;
      if (in_score && score_last) begin
        anchor_passed <= passed_next;
      end else if (pos_eff == '0) begin
        anchor_passed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_box) begin
        box_values[pos_eff[1:0]] <= value;
      end
      if (!in_box && !in_score && !k[0]) begin
        keypoint_x_hold <= value;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= accept && emit;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // truncate toward zero after the fraction shift
  function automatic logic signed [PROD_W-1:0] trunc_shift(
    input logic signed [PROD_W-1:0] p,
    input logic [4:0]               sh
  );
    logic signed [PROD_W-1:0] bias;
    bias = p[PROD_W-1] ? ((PROD_W'(1) << sh) - PROD_W'(1)) : '0;
    return (p + bias) >>> sh;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [PROD_W-1:0] q
  );
    logic signed [COORD_W-1:0] r;
    if (q > COORD_HI) begin
      r = COORD_HI[COORD_W-1:0];
    end else if (q < COORD_LO) begin
      r = COORD_LO[COORD_W-1:0];
    end else begin
      r = q[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat_point(
    input logic signed [PROD_W-1:0] q
  );
    logic signed [VALUE_W-1:0] r;
    if (q > POINT_HI) begin
      r = POINT_HI[VALUE_W-1:0];
    end else if (q < POINT_LO) begin
      r = POINT_LO[VALUE_W-1:0];
    end else begin
      r = q[VALUE_W-1:0];
    end
    return r;
  endfunction

  assign scale_s = $signed({1'b0, inv_scale});

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag <= tag_next;
      for (int i = 0; i < LANES; i++) begin
        s1_opnd[i] <= opnd_next[i];
      end
      s2_tag <= s1_tag;
      for (int i = 0; i < LANES; i++) begin
        s2_prod[i] <= s1_opnd[i] * scale_s;
      end
      kind        <= s2_tag.kind;
      class_id    <= s2_tag.class_id;
      score       <= s2_tag.score;
      point_index <= s2_tag.point_index;
      last        <= s2_tag.last;
      if (s2_tag.kind == KIND_BOX) begin
        left       <= sat_coord(trunc_shift(s2_prod[0], EDGE_SHIFT));
        top        <= sat_coord(trunc_shift(s2_prod[1], EDGE_SHIFT));
        box_width  <= sat_coord(trunc_shift(s2_prod[2], SIZE_SHIFT));
        box_height <= sat_coord(trunc_shift(s2_prod[3], SIZE_SHIFT));
        point_x    <= '0;
        point_y    <= '0;
      end else begin
        left       <= '0;
        top        <= '0;
        box_width  <= '0;
        box_height <= '0;
        point_x    <= sat_point(trunc_shift(s2_prod[0], POINT_SHIFT));
        point_y    <= sat_point(trunc_shift(s2_prod[1], POINT_SHIFT));
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (en && s1_valid) |=> s2_valid)
    else $error("multiply stage lost a result");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(position) && $stable(best_score))
    else $error("anchor state moved during output stall");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position < POS_W'(BOX_FIELDS + MAX_CLASSES + KEYPOINT_VALUES))
    else $error("position beyond longest anchor");

  a_box_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_BOX) |-> (point_x == '0 && point_y == '0 && !last))
    else $error("box result carries keypoint fields");
`endif

endmodule
`default_nettype wire

/* tb/anchor_decode_monitor.sv */
// ----------------------------------------------------------------------------
// anchor_decode_monitor
// Watches the register port and both streams of the anchor decode unit,
// predicts the box and keypoint results of every accepted feature value and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module anchor_decode_monitor #(
  parameter int MAX_CLASSES = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [dad_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dad_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [dad_pkg::VALUE_W-1:0]     value,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic                                   kind,
  input  logic [dad_pkg::CLASS_W-1:0]            class_id,
  input  logic signed [dad_pkg::VALUE_W-1:0]     score,
  input  logic signed [dad_pkg::COORD_W-1:0]     left,
  input  logic signed [dad_pkg::COORD_W-1:0]     top,
  input  logic signed [dad_pkg::COORD_W-1:0]     box_width,
  input  logic signed [dad_pkg::COORD_W-1:0]     box_height,
  input  logic [dad_pkg::POINT_IDX_W-1:0]        point_index,
  input  logic signed [dad_pkg::VALUE_W-1:0]     point_x,
  input  logic signed [dad_pkg::VALUE_W-1:0]     point_y,
  input  logic                                   last,
  output int                                     fails,
  output int                                     results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import dad_pkg::*;

  typedef struct packed {
    kind_t                     kind;
    logic [CLASS_W-1:0]        class_id;
    logic signed [VALUE_W-1:0] score;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] box_width;
    logic signed [COORD_W-1:0] box_height;
    logic [POINT_IDX_W-1:0]    point_index;
    logic signed [VALUE_W-1:0] point_x;
    logic signed [VALUE_W-1:0] point_y;
    logic                      last;
  } anchor_result_t;

  anchor_result_t pending_results[$];
  int fail_total;

  logic [CC_W-1:0]           cc_q;
  logic [THR_W-1:0]          thr_q;
  logic [SCALE_W-1:0]        scale_q;
  int                        pos;
  logic signed [VALUE_W-1:0] best_sc;
  logic [CLASS_W-1:0]        best_cls;
  logic signed [VALUE_W-1:0] box_v [BOX_FIELDS];
  logic signed [VALUE_W-1:0] kx_hold;
  bit                        passed;

  function automatic longint scaled(longint num, int shift);
    longint prod;
    prod = num * longint'(scale_q);
    // truncate toward zero
    if (prod < 0) return -((-prod) >> shift);
    return prod >> shift;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void predict(logic signed [VALUE_W-1:0] v);
    int slots, span, cls, k;
    longint x, y, w, h;
    anchor_result_t r;
    slots = (cc_q == 0) ? 1 : ((int'(cc_q) > MAX_CLASSES) ? MAX_CLASSES : int'(cc_q));
    span = BOX_FIELDS + slots + KEYPOINT_VALUES;
    if (pos >= span) pos = 0;
    if (pos == 0) passed = 1'b0;
    r = '0;
    if (pos < BOX_FIELDS) begin
      box_v[pos] = v;
    end else if (pos < BOX_FIELDS + slots) begin
      cls = pos - BOX_FIELDS;
      if (cls == 0 || v > best_sc) begin
        best_sc = v;
        best_cls = CLASS_W'(cls);
      end
      if (cls == slots - 1) begin
        passed = longint'(best_sc) >= longint'(thr_q);
        if (passed) begin
          x = box_v[0];
          y = box_v[1];
          w = box_v[2];
          h = box_v[3];
          r.kind = KIND_BOX;
          r.class_id = best_cls;
          r.score = best_sc;
          r.left = COORD_W'(clamp(scaled(2 * x - w, 25), -32768, 32767));
          r.top = COORD_W'(clamp(scaled(2 * y - h, 25), -32768, 32767));
          r.box_width = COORD_W'(clamp(scaled(w, 24), -32768, 32767));
          r.box_height = COORD_W'(clamp(scaled(h, 24), -32768, 32767));
          pending_results.push_back(r);
        end
      end
    end else begin
      k = pos - BOX_FIELDS - slots;
      if (k % 2 == 0) begin
        kx_hold = v;
      end else if (passed) begin
        r.kind = KIND_POINT;
        r.class_id = best_cls;
        r.score = best_sc;
        r.point_index = POINT_IDX_W'(k >> 1);
        r.point_x = VALUE_W'(clamp(scaled(kx_hold, 16), -8388608, 8388607));
        r.point_y = VALUE_W'(clamp(scaled(v, 16), -8388608, 8388607));
        r.last = (k == KEYPOINT_VALUES - 1);
        pending_results.push_back(r);
      end
    end
    pos = (pos + 1 >= span) ? 0 : pos + 1;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_total++;
    end
  endfunction

  function automatic void take_result();
    anchor_result_t want;
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing pending: kind %0d class %0d", kind, class_id);
      fail_total++;
    end else begin
      want = pending_results.pop_front();
      check_field("kind", want.kind, kind);
      check_field("class_id", want.class_id, class_id);
      check_field("score", want.score, score);
      check_field("left", want.left, left);
      check_field("top", want.top, top);
      check_field("box_width", want.box_width, box_width);
      check_field("box_height", want.box_height, box_height);
      check_field("point_index", want.point_index, point_index);
      check_field("point_x", want.point_x, point_x);
      check_field("point_y", want.point_y, point_y);
      check_field("last", want.last, last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cc_q = CLASS_COUNT_RST;
      thr_q = THRESHOLD_RST;
      scale_q = INV_SCALE_RST;
      pos = 0;
      best_sc = '0;
      best_cls = '0;
      for (int i = 0; i < BOX_FIELDS; i++) box_v[i] = '0;
      kx_hold = '0;
      passed = 1'b0;
      pending_results.delete();
      fail_total = 0;
    end else begin
      // a result never shares an edge with the transfer that causes it
      if (out_valid && out_ready) take_result();
      if (cfg_we) begin
        case (cfg_index)
          REG_CLASS_COUNT: cc_q = cfg_data[CC_W-1:0];
          REG_THRESHOLD:   thr_q = cfg_data[THR_W-1:0];
          REG_INV_SCALE:   scale_q = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict(value);
    end
    fails <= fail_total;
    results_due <= pending_results.size();
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives feature values and register writes into the anchor decode unit:
// directed extreme anchors, fixed corner settings, class count changes in
// the middle of an anchor, then random anchors under random settings, with
// random idling on both streams and a long output hold-off. The monitor
// beside the block predicts and checks every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dad_pkg::*;

  localparam int MAX_CLASSES = 64;
  localparam int ITEM_GOAL = 1700;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] value;
  logic                      out_valid;
  logic                      out_ready;
  logic                      kind;
  logic [CLASS_W-1:0]        class_id;
  logic signed [VALUE_W-1:0] score;
  logic signed [COORD_W-1:0] left;
  logic signed [COORD_W-1:0] top;
  logic signed [COORD_W-1:0] box_width;
  logic signed [COORD_W-1:0] box_height;
  logic [POINT_IDX_W-1:0]    point_index;
  logic signed [VALUE_W-1:0] point_x;
  logic signed [VALUE_W-1:0] point_y;
  logic                      last;
  int                        fails;
  int                        results_due;

  bit              tx_idle_en;
  bit              rx_idle_en;
  int              hold_request;
  int              items_sent;
  logic [CC_W-1:0] cc_now;
  logic [THR_W-1:0] thr_now;

  detection_anchor_decode_unit #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .class_id(class_id), .score(score),
    .left(left), .top(top), .box_width(box_width), .box_height(box_height),
    .point_index(point_index), .point_x(point_x), .point_y(point_y), .last(last)
  );

  anchor_decode_monitor #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_monitor (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .class_id(class_id), .score(score),
    .left(left), .top(top), .box_width(box_width), .box_height(box_height),
    .point_index(point_index), .point_x(point_x), .point_y(point_y), .last(last),
    .fails(fails), .results_due(results_due)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  // output side: random idling and a counted hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !(rx_idle_en && $urandom_range(0, 99) < 36);
      end
    end
  end

  function automatic logic [VALUE_W-1:0] any_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return VALUE_W'($urandom);
    if (pick == 3) begin
      case ($urandom_range(0, 4))
        0: return 24'h7FFFFF;
        1: return 24'h800000;
        2: return 24'h000000;
        3: return 24'hFFFFFF;
        default: return 24'h000001;
      endcase
    end
    return VALUE_W'(int'($urandom_range(0, 200000)) - 100000);
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] v);
    while (tx_idle_en && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_points(input int n);
    for (int i = 0; i < n; i++) send_value(any_value());
  endtask

  // mode: 0 all below threshold, 1 raw, 2 near threshold, 3 ties, 4 all pass
  task automatic send_scores(input int n, input int mode);
    int s, prev_s;
    prev_s = 0;
    for (int c = 0; c < n; c++) begin
      case (mode)
        0: s = int'(thr_now) - int'($urandom_range(1, 2000));
        1: s = int'(VALUE_W'($urandom));
        3: s = (c > 0 && $urandom_range(0, 1) == 1) ? prev_s
                                                    : int'(thr_now) + int'($urandom_range(0, 40)) - 20;
        4: s = int'($urandom_range(512, 100000));
        default: s = int'(thr_now) + int'($urandom_range(0, 600)) - 300;
      endcase
      if (mode == 1) s = int'($signed(VALUE_W'(s)));
      prev_s = s;
      send_value(VALUE_W'(s));
    end
  endtask

  task automatic send_anchor(input bit force_pass);
    int slots;
    slots = (cc_now == 0) ? 1 : ((int'(cc_now) > MAX_CLASSES) ? MAX_CLASSES : int'(cc_now));
    send_points(BOX_FIELDS);
    send_scores(slots, force_pass ? 4 : int'($urandom_range(0, 4)));
    send_points(KEYPOINT_VALUES);
  endtask

  // wait until the block is empty before touching its registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CC_W-1:0] cc, input logic [THR_W-1:0] thr,
                           input logic [SCALE_W-1:0] scale);
    settle();
    write_reg(REG_CLASS_COUNT, {13'($urandom), cc});
    write_reg(REG_THRESHOLD, {11'($urandom), thr});
    write_reg(REG_INV_SCALE, scale);
    cfg_we <= 1'b0;
    cc_now = cc;
    thr_now = thr;
  endtask

  initial begin
    logic [VALUE_W-1:0] opening [26];
    logic [CC_W-1:0]    cc;
    logic [THR_W-1:0]   thr;
    logic [SCALE_W-1:0] scale;
    int                 pick, slots, n;

    opening = '{24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h000080,
                24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001, 24'h000000,
                24'h000100, 24'h800000, 24'h7FFFFF,
                24'h000100, 24'h000200, 24'h000080, 24'h000040, 24'h00007F,
                24'h0AAAAA, 24'h555555, 24'hF55555, 24'h2AAAAA, 24'h123456,
                24'hEDCBA9, 24'h000000, 24'hFFFFFF};

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    value = '0;
    out_ready = 1'b0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_request = 0;
    items_sent = 0;
    cc_now = CLASS_COUNT_RST;
    thr_now = THRESHOLD_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extreme box and keypoints at the threshold, then just below it
    foreach (opening[i]) send_value(opening[i]);

    // long output hold-off while anchors keep coming
    settle();
    write_reg(REG_UNUSED, 20'($urandom));
    cfg_we <= 1'b0;
    configure(7'd3, 9'd0, 20'd65536);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_request = 400;
    repeat (4) send_anchor(1'b1);

    // corner settings, first with no idling, then with idling
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    configure(7'd64, 9'd256, 20'hFFFFF);
    send_anchor(1'b1);
    send_anchor(1'b0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    configure(7'd0, 9'd128, 20'd1);
    repeat (6) send_anchor(1'b0);
    configure(7'd127, 9'd511, 20'd0);
    send_anchor(1'b1);
    send_anchor(1'b0);
    configure(7'd65, 9'd100, 20'd32768);
    send_anchor(1'b1);
    configure(7'd2, 9'd0, 20'hFFFFF);
    repeat (8) send_anchor(1'b0);

    // class count shrinks past the current position: next value opens an anchor
    configure(7'd8, 9'd0, 20'd65536);
    send_points(BOX_FIELDS);
    send_scores(8, 4);
    send_points(2);
    configure(7'd1, 9'd0, 20'd65536);
    repeat (2) send_anchor(1'b0);

    // class count grows during the scores
    configure(7'd2, 9'd0, 20'd65536);
    send_points(BOX_FIELDS);
    send_scores(1, 4);
    configure(7'd6, 9'd0, 20'd65536);
    send_scores(5, 2);
    send_points(KEYPOINT_VALUES);

    // class count shrinks onto the first keypoint value
    configure(7'd6, 9'd0, 20'd65536);
    send_points(BOX_FIELDS);
    send_scores(3, 4);
    configure(7'd3, 9'd0, 20'd65536);
    send_points(KEYPOINT_VALUES);

    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) cc = CC_W'($urandom_range(1, 6));
      else if (pick < 17) cc = CC_W'($urandom_range(7, 24));
      else if (pick == 17) cc = '0;
      else cc = CC_W'($urandom_range(64, 127));
      thr = ($urandom_range(0, 4) == 0) ? THR_W'($urandom_range(257, 511))
                                        : THR_W'($urandom_range(0, 256));
      pick = $urandom_range(0, 9);
      if (pick < 4) scale = SCALE_W'($urandom_range(16384, 262144));
      else if (pick < 7) scale = SCALE_W'($urandom);
      else if (pick == 7) scale = '0;
      else if (pick == 8) scale = 20'hFFFFF;
      else scale = SCALE_W'($urandom_range(1, 255));
      tx_idle_en = ($urandom_range(0, 5) != 0);
      rx_idle_en = ($urandom_range(0, 5) != 0);
      configure(cc, thr, scale);
      slots = (cc == 0) ? 1 : ((int'(cc) > MAX_CLASSES) ? MAX_CLASSES : int'(cc));
      n = (slots > 24) ? 1 : int'($urandom_range(3, 10));
      repeat (n) send_anchor(1'b0);
    end

    settle();
    repeat (16) @(posedge clk);
    if (fails == 0 && results_due == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
